// ===== rtl/core/sbpm_pkg.sv =====
// Package: shared types, constants and state codes for the spectrum bar peak meter.
`timescale 1ns / 1ps
package sbpm_pkg;

	localparam int NUM_BINS_DEF = 512;
	localparam int MAX_BARS_DEF = 64;
	localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;

	localparam logic [15:0] MIN_DB_RST = 16'hA000;
	localparam logic [15:0] MAX_DB_RST = 16'h0000;
	localparam logic [15:0] DECAY_RST  = 16'd62259;
	localparam logic [6:0]  COUNT_RST  = 7'd40;

	localparam logic [1:0] REG_MIN_DB = 2'd0;
	localparam logic [1:0] REG_MAX_DB = 2'd1;
	localparam logic [1:0] REG_DECAY  = 2'd2;
	localparam logic [1:0] REG_COUNT  = 2'd3;

	localparam logic CMD_RANGE = 1'b0;
	localparam logic CMD_BIN   = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         bar_slot;
		logic [8:0]         range_low;
		logic [9:0]         range_high;
		logic signed [23:0] bin_re;
		logic signed [23:0] bin_im;
		logic               frame_end;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  bar_number;
		logic [15:0] level;
		logic [15:0] peak;
		logic        last_bar;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BIN,
		ST_BAR_START,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_LOG_NORM,
		ST_LOG_SQ,
		ST_DB,
		ST_LEVEL,
		ST_DIV,
		ST_PEAK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic store_bin;
		logic write_range;
		logic clear_counter;
		logic bar_start;
		logic scan_step;
		logic log_norm;
		logic log_sq;
		logic db_calc;
		logic level_calc;
		logic div_step;
		logic peak_calc;
		logic out_load;
		logic next_bar;
	} ctrl_t;

	typedef struct packed {
		logic scan_done;
		logic log_done;
		logic div_needed;
		logic div_done;
		logic bars_done;
		logic no_bars;
	} stat_t;

endpackage

// ===== rtl/core/spectrum_bar_peak_meter_unit.sv =====
// Top level: configuration registers, controller and datapath of the bar peak meter.
// A bin transfer stalls the input until the controller is idle again; a frame end then walks
//   every bar in use (range scan, log2, dB, level divide when needed, peak) with the input stalled,
//   and a stalled result holds the walk before the next result.
// Reset (arst_n low, asynchronous): registers take their defaults, peaks clear,
//   bin counter clears; bin power and range tables stay undefined until written.
`timescale 1ns / 1ps
module spectrum_bar_peak_meter_unit #(
	parameter int NUM_BINS = sbpm_pkg::NUM_BINS_DEF,
	parameter int MAX_BARS = sbpm_pkg::MAX_BARS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sbpm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sbpm_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import sbpm_pkg::*;

	logic [15:0] min_db_q, max_db_q, decay_q;
	logic [6:0]  count_q;
	ctrl_t       ctrl;
	stat_t       stat;

	// Hold configuration; the user must write it only while idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_db_q <= MIN_DB_RST;
			max_db_q <= MAX_DB_RST;
			decay_q  <= DECAY_RST;
			count_q  <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DB: min_db_q <= cfg_data;
				REG_MAX_DB: max_db_q <= cfg_data;
				REG_DECAY:  decay_q  <= cfg_data;
				REG_COUNT:  count_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Sequence each transfer and the per-bar walk.
	sbpm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .ctrl(ctrl)
	);

	// Store powers, scan ranges, convert to level, update peaks.
	sbpm_datapath #(.NUM_BINS(NUM_BINS), .MAX_BARS(MAX_BARS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data),
		.ctrl(ctrl), .stat(stat),
		.min_db(min_db_q), .max_db(max_db_q), .peak_decay(decay_q), .bar_count(count_q),
		.out_stall(out_stall), .out_valid(out_valid), .out_data(out_data)
	);

endmodule

// ===== rtl/core/sbpm_ctrl.sv =====
// Controller: sequences bin storage and the per-bar frame walk.
`timescale 1ns / 1ps
module sbpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sbpm_pkg::in_item_t in_data,
	output logic              in_stall,
	input  logic              out_valid,
	input  logic              out_stall,
	input  sbpm_pkg::stat_t   stat,
	output sbpm_pkg::ctrl_t   ctrl
);
	import sbpm_pkg::*;

	state_t state_q, state_d;
	logic   fe_q;
	logic   acc;

	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fe_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) fe_q <= in_data.frame_end;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && in_data.cmd == CMD_BIN) state_d = ST_BIN;
			end
			ST_BIN: begin
				if (!fe_q) state_d = ST_IDLE;
				else if (stat.no_bars) state_d = ST_IDLE;
				else state_d = ST_BAR_START;
			end
			ST_BAR_START: state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_done) state_d = ST_SCAN_TAIL;
			end
			ST_SCAN_TAIL: state_d = ST_LOG_NORM;
			ST_LOG_NORM:  state_d = ST_LOG_SQ;
			ST_LOG_SQ: begin
				if (stat.log_done) state_d = ST_DB;
			end
			ST_DB: state_d = ST_LEVEL;
			ST_LEVEL: begin
				state_d = stat.div_needed ? ST_DIV : ST_PEAK;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_PEAK;
			end
			ST_PEAK: begin
				if (!out_valid || !out_stall) state_d = ST_OUT;
			end
			ST_OUT: state_d = stat.bars_done ? ST_IDLE : ST_BAR_START;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.store_bin   = acc && in_data.cmd == CMD_BIN;
				ctrl.write_range = acc && in_data.cmd == CMD_RANGE;
			end
			ST_BIN: begin
				ctrl.clear_counter = fe_q;
			end
			ST_BAR_START: ctrl.bar_start = 1'b1;
			ST_SCAN:      ctrl.scan_step = 1'b1;
			ST_LOG_NORM:  ctrl.log_norm = 1'b1;
			ST_LOG_SQ:    ctrl.log_sq = 1'b1;
			ST_DB:        ctrl.db_calc = 1'b1;
			ST_LEVEL:     ctrl.level_calc = 1'b1;
			ST_DIV:       ctrl.div_step = 1'b1;
			ST_PEAK:      ctrl.peak_calc = !out_valid || !out_stall;
			ST_OUT: begin
				ctrl.out_load = 1'b1;
				ctrl.next_bar = 1'b1;
			end
			default: ctrl = '0;
		endcase
	end

endmodule

// ===== rtl/core/sbpm_datapath.sv =====
// Datapath: bin power memory, range tables, scan, log2, dB, level divider, peak hold.
`timescale 1ns / 1ps
module sbpm_datapath #(
	parameter int NUM_BINS = sbpm_pkg::NUM_BINS_DEF,
	parameter int MAX_BARS = sbpm_pkg::MAX_BARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sbpm_pkg::in_item_t in_data,
	input  sbpm_pkg::ctrl_t    ctrl,
	output sbpm_pkg::stat_t    stat,
	input  logic [15:0]        min_db,
	input  logic [15:0]        max_db,
	input  logic [15:0]        peak_decay,
	input  logic [6:0]         bar_count,
	input  logic               out_stall,
	output logic               out_valid,
	output sbpm_pkg::out_item_t out_data
);
	import sbpm_pkg::*;

	localparam int BW = $clog2(NUM_BINS);
	localparam int CW = $clog2(NUM_BINS + 1);
	localparam int SW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
	localparam int NW = $clog2(MAX_BARS + 1);

	logic [48:0] pwr_mem [NUM_BINS];
	logic [8:0]  lo_mem  [MAX_BARS];
	logic [9:0]  hi_mem  [MAX_BARS];
	logic [15:0] peak_mem [MAX_BARS];
	logic [MAX_BARS-1:0] peak_vld_q;

	logic [CW-1:0] bin_cnt_q;
	logic [NW-1:0] bar_q;
	logic [NW-1:0] count_w;

	// bin power
	logic [47:0] re_sq, im_sq;
	assign re_sq = 48'($signed(in_data.bin_re)) * 48'($signed(in_data.bin_re));
	assign im_sq = 48'($signed(in_data.bin_im)) * 48'($signed(in_data.bin_im));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
		end else if (ctrl.clear_counter) begin
			bin_cnt_q <= '0;
		end else if (ctrl.store_bin && bin_cnt_q < CW'(NUM_BINS)) begin
			bin_cnt_q <= bin_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.store_bin && bin_cnt_q < CW'(NUM_BINS))
			pwr_mem[bin_cnt_q[BW-1:0]] <= {1'b0, re_sq} + {1'b0, im_sq};
	end

	always_ff @(posedge clk) begin
		if (ctrl.write_range && {1'b0, in_data.bar_slot} < 7'(MAX_BARS)) begin
			lo_mem[in_data.bar_slot[SW-1:0]] <= in_data.range_low;
			hi_mem[in_data.bar_slot[SW-1:0]] <= in_data.range_high;
		end
	end

	assign count_w = (bar_count > 7'(MAX_BARS)) ? NW'(MAX_BARS) : NW'(bar_count);
	assign stat.no_bars = (count_w == '0);
	assign stat.bars_done = (bar_q + 1'b1 == count_w);

	// scan
	logic [9:0]  idx_q, hi_q;
	logic        rd_vld_s1;
	logic [48:0] rd_s1, best_q;
	logic [15:0] peak_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (ctrl.clear_counter) bar_q <= '0;
			else if (ctrl.next_bar) bar_q <= bar_q + 1'b1;
			rd_vld_s1 <= ctrl.scan_step && (idx_q < hi_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.bar_start) begin
			idx_q  <= {1'b0, lo_mem[bar_q[SW-1:0]]};
			hi_q   <= (hi_mem[bar_q[SW-1:0]] > 10'(NUM_BINS)) ? 10'(NUM_BINS)
			          : hi_mem[bar_q[SW-1:0]];
			best_q <= '0;
			peak_rd_q <= peak_vld_q[bar_q[SW-1:0]] ? peak_mem[bar_q[SW-1:0]] : 16'd0;
		end else begin
			if (ctrl.scan_step) idx_q <= idx_q + 1'b1;
			if (rd_vld_s1 && rd_s1 > best_q) best_q <= rd_s1;
		end
		rd_s1 <= pwr_mem[idx_q[BW-1:0]];
	end

	assign stat.scan_done = (idx_q + 1'b1 >= hi_q);

	// log2: leading one, then one squaring per cycle
	logic [5:0]  e_q;
	logic [31:0] m_q;
	logic [15:0] frac_q;
	logic [4:0]  sq_cnt_q;
	logic [5:0]  lead;
	logic [63:0] msq;

	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 49; i++)
			if (best_q[i]) lead = 6'(i);
	end

	assign msq = 64'(m_q) * 64'(m_q);
	assign stat.log_done = (sq_cnt_q == 5'd15);

	always_ff @(posedge clk) begin
		if (ctrl.log_norm) begin
			e_q      <= lead;
			m_q      <= (lead >= 6'd30) ? 32'(best_q >> (lead - 6'd30))
			            : 32'(best_q << (6'd30 - lead));
			frac_q   <= '0;
			sq_cnt_q <= '0;
		end else if (ctrl.log_sq) begin
			sq_cnt_q <= sq_cnt_q + 1'b1;
			if (msq[61]) begin
				m_q    <= 32'(msq >> 31);
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				m_q    <= 32'(msq >> 30);
				frac_q <= {frac_q[14:0], 1'b0};
			end
		end
	end

	// dB
	logic [40:0] db_prod;
	logic signed [16:0] db_q;
	logic [16:0] db_t;
	assign db_prod = 41'({e_q, frac_q}) * 41'(DB_PER_LOG2_Q16) + 41'(1 << 23);
	assign db_t = 17'(db_prod >> 24);

	always_ff @(posedge clk) begin
		if (ctrl.db_calc) db_q <= (db_t > 17'd32767) ? 17'sd32767 : $signed(db_t);
	end

	// level
	logic signed [17:0] d_w, r_w;
	logic [15:0] level_q;
	logic [16:0] r_q;
	logic [32:0] rem_q;
	logic [15:0] quo_q;
	logic [4:0]  div_cnt_q;
	logic        zero_q;
	logic [32:0] rem_sh;

	assign d_w = 18'(db_q) - 18'($signed(min_db));
	assign r_w = 18'($signed(max_db)) - 18'($signed(min_db));
	assign stat.div_needed = !zero_q && r_w > 0 && d_w > 0 && d_w < r_w;
	assign stat.div_done = (div_cnt_q == 5'd15);
	assign rem_sh = {rem_q[31:0], 1'b0};

	always_ff @(posedge clk) begin
		if (ctrl.log_norm) zero_q <= (best_q == '0);
		if (ctrl.level_calc) begin
			r_q       <= 17'(r_w);
			rem_q     <= 33'(d_w);
			quo_q     <= '0;
			div_cnt_q <= '0;
			if (zero_q) level_q <= 16'd0;
			else if (r_w <= 0) level_q <= (db_q >= 17'($signed(max_db))) ? 16'hFFFF : 16'd0;
			else if (d_w <= 0) level_q <= 16'd0;
			else if (d_w >= r_w) level_q <= 16'hFFFF;
		end else if (ctrl.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
			if (rem_sh >= {16'd0, r_q}) begin
				rem_q   <= rem_sh - {16'd0, r_q};
				level_q <= {quo_q[14:0], 1'b1};
				quo_q   <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q   <= rem_sh;
				level_q <= {quo_q[14:0], 1'b0};
				quo_q   <= {quo_q[14:0], 1'b0};
			end
		end
	end

	// peak and output
	logic [31:0] pk_prod;
	logic [15:0] pk_dec, pk_q;
	assign pk_prod = 32'(peak_rd_q) * 32'(peak_decay);
	assign pk_dec = pk_prod[31:16];

	always_ff @(posedge clk) begin
		if (ctrl.peak_calc) pk_q <= (level_q > pk_dec) ? level_q : pk_dec;
		if (ctrl.out_load) begin
			peak_mem[bar_q[SW-1:0]] <= pk_q;
			out_data.bar_number <= 6'(bar_q);
			out_data.level      <= level_q;
			out_data.peak       <= pk_q;
			out_data.last_bar   <= stat.bars_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_vld_q <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (ctrl.out_load) begin
				peak_vld_q[bar_q[SW-1:0]] <= 1'b1;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/sbpm_checker.sv =====
// Checker: port-level properties of the bar peak meter, bound to the top level.
`timescale 1ns / 1ps
module sbpm_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input sbpm_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input sbpm_pkg::out_item_t out_data
);
	import sbpm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	a_walk_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_bar |-> in_stall)
		else $error("input open during frame walk");

	a_range_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_RANGE |=> !in_stall)
		else $error("range write stalled input");

	a_bin_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_BIN |=> in_stall)
		else $error("bin not processed");

endmodule

bind spectrum_bar_peak_meter_unit sbpm_props u_sbpm_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/sbpm_checker.sv =====
// Checker: watches the bin and result channels, predicts each bar result and compares it.
`timescale 1ns / 1ps
module sbpm_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  sbpm_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  sbpm_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output int                  fails,
	output int                  pending,
	output int                  results_seen
);
	import sbpm_pkg::*;

	logic [48:0]        power_mem [NUM_BINS_DEF];
	logic [8:0]         lo_tab [MAX_BARS_DEF];
	logic [9:0]         hi_tab [MAX_BARS_DEF];
	logic [15:0]        hold_tab [MAX_BARS_DEF];
	int unsigned        bin_idx;
	logic signed [15:0] floor_db;
	logic signed [15:0] ceil_db;
	logic [15:0]        decay;
	logic [6:0]         bars_cfg;
	out_item_t          bar_q [$];

	function automatic logic [31:0] log2_fix(logic [63:0] p);
		int e;
		int i;
		logic [63:0] m;
		logic [15:0] frac;
		e = 0;
		while (e < 63 && (p >> (e + 1)) != 0)
			e++;
		if (e >= 30)
			m = p >> (e - 30);
		else
			m = p << (30 - e);
		frac = '0;
		for (i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac[i] = 1'b1;
			end
		end
		return {e[15:0], frac};
	endfunction

	function automatic logic [15:0] level_of(logic [63:0] p);
		longint db;
		longint d;
		longint r;
		longint lg;
		if (p == 0)
			return 16'd0;
		lg = longint'(log2_fix(p));
		db = (lg * 197283 + 64'sd8388608) >>> 24;
		if (db > 32767)
			db = 32767;
		r = longint'(ceil_db) - longint'(floor_db);
		if (r <= 0)
			return (db >= longint'(ceil_db)) ? 16'hFFFF : 16'd0;
		d = db - longint'(floor_db);
		if (d <= 0)
			return 16'd0;
		if (d >= r)
			return 16'hFFFF;
		return 16'((d << 16) / r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint re;
		longint im;
		int n;
		int hi;
		logic [48:0] best;
		logic [31:0] pk;
		logic [15:0] lv;
		out_item_t want;
		if (!arst_n) begin
			for (int k = 0; k < MAX_BARS_DEF; k++)
				hold_tab[k] = '0;
			bin_idx = 0;
			floor_db = MIN_DB_RST;
			ceil_db = MAX_DB_RST;
			decay = DECAY_RST;
			bars_cfg = COUNT_RST;
			bar_q.delete();
			fails = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_DB: floor_db = cfg_data;
					REG_MAX_DB: ceil_db = cfg_data;
					REG_DECAY:  decay = cfg_data;
					REG_COUNT:  bars_cfg = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (in_data.cmd == CMD_RANGE) begin
					lo_tab[in_data.bar_slot] = in_data.range_low;
					hi_tab[in_data.bar_slot] = in_data.range_high;
				end else begin
					if (bin_idx < NUM_BINS_DEF) begin
						re = in_data.bin_re;
						im = in_data.bin_im;
						power_mem[bin_idx] = 49'(re * re + im * im);
						bin_idx++;
					end
					if (in_data.frame_end) begin
						bin_idx = 0;
						n = (bars_cfg > MAX_BARS_DEF) ? MAX_BARS_DEF : int'(bars_cfg);
						for (int b = 0; b < n; b++) begin
							hi = hi_tab[b];
							if (hi > NUM_BINS_DEF)
								hi = NUM_BINS_DEF;
							best = '0;
							for (int i = lo_tab[b]; i < hi; i++)
								if (power_mem[i] > best)
									best = power_mem[i];
							lv = level_of(64'(best));
							pk = (32'(hold_tab[b]) * 32'(decay)) >> 16;
							if (32'(lv) > pk)
								pk = 32'(lv);
							hold_tab[b] = pk[15:0];
							want.bar_number = 6'(b);
							want.level = lv;
							want.peak = pk[15:0];
							want.last_bar = (b + 1 == n);
							bar_q.push_back(want);
						end
					end
				end
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (bar_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("ERROR: unexpected result bar %0d level %0d peak %0d last %0d",
							out_data.bar_number, out_data.level, out_data.peak,
							out_data.last_bar);
				end else begin
					want = bar_q.pop_front();
					if (out_data !== want) begin
						fails++;
						if (fails <= 10)
							$display({"ERROR: bar result mismatch: expected bar %0d level %0d ",
								"peak %0d last %0d, got bar %0d level %0d peak %0d last %0d"},
								want.bar_number, want.level, want.peak, want.last_bar,
								out_data.bar_number, out_data.level, out_data.peak,
								out_data.last_bar);
					end
				end
			end
		end
		pending = bar_q.size();
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives bins, range writes and registers into the bar peak meter and gives the verdict.
`timescale 1ns / 1ps
module tb;
	import sbpm_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int WBINS = 16;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int  fails;
	int  pending;
	int  results_seen;
	int  items_sent;
	int  frames_sent;
	int  cycles;
	logic in_took;
	int  stall_left;
	logic stall_on;

	spectrum_bar_peak_meter_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sbpm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending), .results_seen(results_seen)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Capture the input transfer at the edge so the driver can read it safely at negedge.
	always @(posedge clk)
		in_took <= in_valid && !in_stall;

	// Hard stop on a hung block.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, pending);
			$display("spectrum_bar_peak_meter_unit verification failed");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(30, 80);
	endfunction

	// Receiver back-pressure: alternate free-running stretches with stall bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			stall_on <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!stall_on && $urandom_range(0, 99) < 40) begin
			stall_on <= 1'b1;
			out_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			stall_on <= 1'b0;
			out_stall <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 6);
		end
	end

	// Bin part: full range, small magnitude or zero.
	function automatic logic [23:0] pick_part();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 24'($urandom);
		if (r < 8)
			return 24'($signed(9'($urandom)));
		return 24'd0;
	endfunction

	// Unused fields carry random noise.
	function automatic in_item_t range_item(int slot, int lo, int hi);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom});
		it.cmd = CMD_RANGE;
		it.bar_slot = 6'(slot);
		it.range_low = 9'(lo);
		it.range_high = 10'(hi);
		return it;
	endfunction

	function automatic in_item_t bin_item(logic [23:0] re, logic [23:0] im, logic fe);
		in_item_t it;
		it = in_item_t'({$urandom, $urandom, $urandom});
		it.cmd = CMD_BIN;
		it.bin_re = re;
		it.bin_im = im;
		it.frame_end = fe;
		return it;
	endfunction

	// Hold the item until its transfer, then idle for a random gap.
	task automatic send(in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(negedge clk);
		while (!in_took);
		items_sent++;
		if (it.cmd == CMD_BIN && it.frame_end)
			frames_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drain every expected result, then let the block go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_all(logic [15:0] lo_db, logic [15:0] hi_db, logic [15:0] dec,
			logic [15:0] cnt);
		settle();
		set_reg(REG_MIN_DB, lo_db);
		set_reg(REG_MAX_DB, hi_db);
		set_reg(REG_DECAY, dec);
		set_reg(REG_COUNT, cnt);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(int nbins);
		for (int k = 0; k < nbins; k++)
			send(bin_item(pick_part(), pick_part(), k == nbins - 1));
	endtask

	// Random mix: range rewrites, short frames and lone bins without a frame end.
	task automatic random_items(int quota, logic drain_mid);
		int done;
		int r;
		int lo;
		int hi;
		int nb;
		done = 0;
		while (done < quota) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				lo = $urandom_range(0, WBINS - 1);
				hi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lo)
					: lo + $urandom_range(1, WBINS - lo);
				send(range_item($urandom_range(0, 63), lo, hi));
				done++;
			end else if (r < 35) begin
				send(bin_item(pick_part(), pick_part(), 1'b0));
				done++;
			end else begin
				nb = $urandom_range(1, 5);
				send_frame(nb);
				done += nb;
			end
			// Hold the sender once until every bar result is back.
			if (drain_mid && done >= quota / 2) begin
				settle();
				drain_mid = 1'b0;
			end
		end
	endtask

	initial begin
		int lo;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		frames_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Load every bar range inside the first bins: full span, tail, empty, inverted, last bin.
		send(range_item(0, 0, WBINS));
		send(range_item(1, 5, WBINS));
		send(range_item(2, 7, 7));
		send(range_item(3, 12, 3));
		send(range_item(4, WBINS - 1, WBINS));
		for (int s = 5; s < 64; s++) begin
			lo = $urandom_range(0, WBINS - 1);
			send(range_item(s, lo, lo + $urandom_range(1, WBINS - lo)));
		end

		// First frame writes every bin that a range covers, extremes first.
		send(bin_item(24'h800000, 24'h800000, 1'b0));
		send(bin_item(24'h7FFFFF, 24'h800000, 1'b0));
		send(bin_item(24'd0, 24'd0, 1'b0));
		for (int k = 3; k < WBINS - 1; k++)
			send(bin_item(pick_part(), pick_part(), 1'b0));
		send(bin_item(pick_part(), pick_part(), 1'b1));

		// Short frames keep older powers; a range write with frame end set makes no result.
		send_frame(1);
		send_frame(3);
		send(range_item(6, 0, 2));
		send_frame(2);

		set_all(16'h8000, 16'h7FFF, 16'hFFFF, 16'd64);
		random_items(4, 1'b0);
		set_all(16'd4000, 16'hF060, 16'd0, 16'd1);
		random_items(4, 1'b1);
		set_all(16'd0, 16'd9000, 16'($urandom), 16'd127);
		random_items(4, 1'b0);
		set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'd0);
		random_items(3, 1'b0);
		set_all(16'($urandom_range(0, 12000)), 16'($urandom_range(12001, 32767)),
			16'($urandom), 16'($urandom_range(1, 64)));
		random_items(4, 1'b0);

		settle();
		$display("summary: %0d items in %0d frames, %0d bar results checked, %0d cycles",
			items_sent, frames_sent, results_seen, cycles);
		$display("  covered dB span extremes, inverted span, decay 0 and full, bar counts 0..127");
		if (fails == 0)
			$display("spectrum_bar_peak_meter_unit verification clean");
		else
			$display("spectrum_bar_peak_meter_unit verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sbpm_pkg.sv
rtl/core/sbpm_ctrl.sv
rtl/core/sbpm_datapath.sv
rtl/core/spectrum_bar_peak_meter_unit.sv
rtl/core/sbpm_checker.sv
tb/sbpm_checker.sv
tb/tb.sv
